// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Decoder modes, character codes, UTF-8 constants and hex digit decode.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_ESC   = 2'd1,
      MODE_HEX   = 2'd2
   } mode_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   localparam int unsigned RUN_MAX   = 5;
   localparam int unsigned HELD_MAX  = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_B         = 8'h62;
   localparam logic [7:0] CHAR_F         = 8'h66;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_FF        = 8'h0C;

   localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF8_CONT      = 8'h80;
   localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;
   localparam logic [15:0] CP_1BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] CP_2BYTE_LIMIT = 16'h0800;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

endpackage

// File: rtl/core/json_string_unescape.sv
// ----------------------------------------------------------------------------
// json_string_unescape: byte-wide JSON string body unescaper
// Decodes backslash escapes and \uXXXX sequences (to UTF-8) in one pass.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one raw string byte per word (req_in_byte) and
//   req_is_final on the last byte of the string body. rsp_ channel carries
//   one unescaped byte per word; rsp_run_last marks the last word caused by
//   a request word, rsp_string_end the last word of the whole string.
//   A request word is decoded in the cycle it is accepted and its run of
//   0 to 5 result bytes is loaded into an output shift register, so the
//   first result word is offered in the cycle after acceptance.
//   Throughput: plain text runs at one word per cycle while rsp_stall is
//   low. Words with no result (a pending backslash or a held hex digit)
//   are still taken as request words but load nothing into the output.
//   The output shift register sets this rate: a new request word is taken
//   when the register is empty or its last word leaves.
//   rsp_stall holds the current result word and backs up into req_stall.
//   Reset returns the decoder to plain text mode and empties the output.
// ----------------------------------------------------------------------------
module json_string_unescape (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import jsu_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [1:0] digits_ff, digits_in;
   logic [7:0] held_ff [HELD_MAX];
   logic       held_we;

   logic [7:0] run_ff [RUN_MAX];
   logic [7:0] run_in [RUN_MAX];
   logic [2:0] run_count_ff, run_count_in;
   logic       fin_ff, fin_in;

   logic [7:0] res [RUN_MAX];
   logic [2:0] k;
   logic       do_plain;
   logic       req_take, rsp_take;
   hex_type    h_cur, h0, h1, h2;
   logic [15:0] cp;

   assign rsp_valid      = (run_count_ff != 3'd0);
   assign rsp_out_byte   = run_ff[0];
   assign rsp_run_last   = (run_count_ff == 3'd1);
   assign rsp_string_end = (run_count_ff == 3'd1) && fin_ff;

   assign req_stall = (run_count_ff > 3'd1) || ((run_count_ff == 3'd1) && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign h_cur = hex_decode(req_in_byte);
   assign h0    = hex_decode(held_ff[0]);
   assign h1    = hex_decode(held_ff[1]);
   assign h2    = hex_decode(held_ff[2]);
   assign cp    = {h0.value, h1.value, h2.value, h_cur.value};

   // decode of the incoming word
   always_comb begin
      for (int i = 0; i < RUN_MAX; i++) begin
         res[i] = 8'h00;
      end
      k         = 3'd0;
      do_plain  = 1'b0;
      held_we   = 1'b0;
      mode_in   = mode_ff;
      digits_in = digits_ff;
      case (mode_ff)
         MODE_ESC: begin
            mode_in = MODE_PLAIN;
            case (req_in_byte)
               CHAR_N: begin res[k] = CHAR_LF;  k = k + 3'd1; end
               CHAR_T: begin res[k] = CHAR_TAB; k = k + 3'd1; end
               CHAR_R: begin res[k] = CHAR_CR;  k = k + 3'd1; end
               CHAR_B: begin res[k] = CHAR_BS;  k = k + 3'd1; end
               CHAR_F: begin res[k] = CHAR_FF;  k = k + 3'd1; end
               CHAR_U: begin
                  if (req_is_final) begin
                     res[k] = CHAR_U;
                     k      = k + 3'd1;
                  end else begin
                     mode_in   = MODE_HEX;
                     digits_in = 2'd0;
                  end
               end
               default: begin res[k] = req_in_byte; k = k + 3'd1; end
            endcase
         end
         MODE_HEX: begin
            if (h_cur.valid && digits_ff == 2'd3) begin
               if (cp < CP_1BYTE_LIMIT) begin
                  res[0] = cp[7:0];
                  k      = 3'd1;
               end else if (cp < CP_2BYTE_LIMIT) begin
                  res[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
                  res[1] = UTF8_CONT | (cp[7:0] & UTF8_CONT_MASK);
                  k      = 3'd2;
               end else begin
                  res[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
                  res[1] = UTF8_CONT | ({2'd0, cp[11:6]} & UTF8_CONT_MASK);
                  res[2] = UTF8_CONT | (cp[7:0] & UTF8_CONT_MASK);
                  k      = 3'd3;
               end
               mode_in   = MODE_PLAIN;
               digits_in = 2'd0;
            end else if (h_cur.valid && !req_is_final) begin
               held_we   = 1'b1;
               digits_in = digits_ff + 2'd1;
            end else begin
               res[k] = CHAR_U;
               k      = k + 3'd1;
               for (int i = 0; i < HELD_MAX; i++) begin
                  if (2'(i) < digits_ff) begin
                     res[k] = held_ff[i];
                     k      = k + 3'd1;
                  end
               end
               mode_in   = MODE_PLAIN;
               digits_in = 2'd0;
               do_plain  = 1'b1;
            end
         end
         default: begin
            mode_in  = MODE_PLAIN;
            do_plain = 1'b1;
         end
      endcase
      if (do_plain) begin
         if (req_in_byte == CHAR_BACKSLASH && !req_is_final) begin
            mode_in = MODE_ESC;
         end else begin
            res[k] = req_in_byte;
            k      = k + 3'd1;
         end
      end
      if (req_is_final) begin
         mode_in   = MODE_PLAIN;
         digits_in = 2'd0;
      end
   end

   // output run shift register
   always_comb begin
      for (int i = 0; i < RUN_MAX; i++) begin
         run_in[i] = run_ff[i];
      end
      run_count_in = run_count_ff;
      fin_in       = fin_ff;
      if (rsp_take) begin
         for (int i = 0; i < RUN_MAX - 1; i++) begin
            run_in[i] = run_ff[i + 1];
         end
         run_count_in = run_count_ff - 3'd1;
      end
      if (req_take && k != 3'd0) begin
         for (int i = 0; i < RUN_MAX; i++) begin
            run_in[i] = res[i];
         end
         run_count_in = k;
         fin_in       = req_is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PLAIN;
         digits_ff    <= 2'd0;
         run_count_ff <= 3'd0;
      end else begin
         run_count_ff <= run_count_in;
         if (req_take) begin
            mode_ff   <= mode_in;
            digits_ff <= digits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RUN_MAX; i++) begin
         run_ff[i] <= run_in[i];
      end
      fin_ff <= fin_in;
      if (req_take && held_we) begin
         held_ff[digits_ff] <= req_in_byte;
      end
   end

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_count_ff <= 3'(RUN_MAX))
      else $error("output run longer than maximum");

   a_digits_mode: assert property (@(posedge clock) disable iff (reset)
      digits_ff != 2'd0 |-> mode_ff == MODE_HEX)
      else $error("hex digits held outside hex mode");

   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      req_take && req_is_final |=> mode_ff == MODE_PLAIN && digits_ff == 2'd0)
      else $error("decoder not back in plain mode after final word");

   a_drain_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_take && run_count_ff > 3'd1 |=> rsp_valid)
      else $error("output run dropped before its last word");

endmodule
